// ----- src/cocc_pkg.sv -----
package cocc_pkg;

    localparam int MAX_OBSTACLES = 64;
    localparam int IDX_W         = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int COUNT_W       = 7;
    localparam int CNT_W         = $clog2(MAX_OBSTACLES + 1);
    localparam int SCAN_W        = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    localparam int COORD_W       = 14;
    localparam int RAD_W         = 10;
    localparam int SUMR_W        = RAD_W + 1;
    localparam int ENTRY_IDX_W   = 6;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 14;

    localparam logic [COORD_W-1:0] WORLD_SIZE_RST = COORD_W'(11200);

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_QUERY   = 1'b1;
    localparam logic KIND_CIRCLE = 1'b0;
    localparam logic KIND_RECT   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WORLD_SIZE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_COUNT = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [RAD_W-1:0]   radius;
    } t_shape;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_corner;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [RAD_W-1:0]   radius;
    } t_query;

    typedef struct packed {
        logic busy;
        logic hit_valid;
        logic hit;
    } t_pipe_status;

endpackage

// ----- src/cocc_hit_pipe.sv -----
module cocc_hit_pipe (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  cocc_pkg::t_shape      i_shape,
    input  cocc_pkg::t_corner     i_corner,
    input  cocc_pkg::t_query      i_query,
    output cocc_pkg::t_pipe_status o_status
);
    import cocc_pkg::*;

    logic [COORD_W-1:0]   near_x;
    logic [COORD_W-1:0]   near_y;
    logic [COORD_W-1:0]   abs_x;
    logic [COORD_W-1:0]   abs_y;
    logic [SUMR_W-1:0]    reach;

    logic                 r_va;
    logic [COORD_W-1:0]   r_ax;
    logic [COORD_W-1:0]   r_ay;
    logic [SUMR_W-1:0]    r_reach;

    logic                 r_vb;
    logic [2*COORD_W-1:0] r_sqx;
    logic [2*COORD_W-1:0] r_sqy;
    logic [2*SUMR_W-1:0]  r_sqr;

    logic                 r_vc;
    logic                 r_hit;

    logic [2*COORD_W:0]   dist_sq;

    // closest point on the obstacle; a circle uses its center
    always_comb begin
        if (i_shape.kind == KIND_RECT) begin
            if (i_query.x < i_shape.x) begin
                near_x = i_shape.x;
            end else if (i_query.x > i_corner.x) begin
                near_x = i_corner.x;
            end else begin
                near_x = i_query.x;
            end
            if (i_query.y < i_shape.y) begin
                near_y = i_shape.y;
            end else if (i_query.y > i_corner.y) begin
                near_y = i_corner.y;
            end else begin
                near_y = i_query.y;
            end
            reach = SUMR_W'(i_query.radius);
        end else begin
            near_x = i_shape.x;
            near_y = i_shape.y;
            reach  = SUMR_W'(i_query.radius) + SUMR_W'(i_shape.radius);
        end
        abs_x = (i_query.x >= near_x) ? (i_query.x - near_x) : (near_x - i_query.x);
        abs_y = (i_query.y >= near_y) ? (i_query.y - near_y) : (near_y - i_query.y);
    end

    assign dist_sq = (2*COORD_W+1)'(r_sqx) + (2*COORD_W+1)'(r_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
        r_ax    <= abs_x;
        r_ay    <= abs_y;
        r_reach <= reach;
        r_sqx   <= (2*COORD_W)'(r_ax) * (2*COORD_W)'(r_ax);
        r_sqy   <= (2*COORD_W)'(r_ay) * (2*COORD_W)'(r_ay);
        r_sqr   <= (2*SUMR_W)'(r_reach) * (2*SUMR_W)'(r_reach);
        // strict: touching is no hit
        r_hit   <= dist_sq < (2*COORD_W+1)'(r_sqr);
    end

    assign o_status.busy      = r_va | r_vb | r_vc;
    assign o_status.hit_valid = r_vc;
    assign o_status.hit       = r_hit;

endmodule

// ----- src/circle_obstacle_collision_check.sv -----
// Channel   Direction  Handshake               Payload
// input     in         i_in_valid / o_in_stall i_req_type .. i_circle_radius
// output    out        o_out_valid / i_out_stall o_out_collides, o_out_outside_world
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A load, a query that fails the world bounds test, or a query with
// obstacle_count 0 has its result valid in the cycle after acceptance.
// Any other query scans N = min(obstacle_count, 64) obstacle entries:
// the obstacle memory delivers one entry per cycle into a 3-stage hit pipeline.
// One item is in flight at a time; o_in_stall is high while a query scans and
// drains, and while a result waits in the output register under i_out_stall.
// Synchronous active-low reset clears control, config and valid registers, not
// data or the obstacle memory. A stalled result holds in the output register.
module circle_obstacle_collision_check (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_req_type,
    input  logic [cocc_pkg::ENTRY_IDX_W-1:0]     i_entry_index,
    input  logic                                 i_entry_kind,
    input  logic [cocc_pkg::COORD_W-1:0]         i_pos_x,
    input  logic [cocc_pkg::COORD_W-1:0]         i_pos_y,
    input  logic [cocc_pkg::COORD_W-1:0]         i_corner_x,
    input  logic [cocc_pkg::COORD_W-1:0]         i_corner_y,
    input  logic [cocc_pkg::RAD_W-1:0]           i_circle_radius,

    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_out_collides,
    output logic                                 o_out_outside_world,

    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [cocc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cocc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import cocc_pkg::*;

    t_shape             shape_mem  [MAX_OBSTACLES];
    t_corner            corner_mem [MAX_OBSTACLES];

    t_state             r_state;
    t_state             n_state;

    logic [COORD_W-1:0] r_world_size;
    logic [COUNT_W-1:0] r_obstacle_count;

    t_query             r_query;
    logic [IDX_W-1:0]   r_idx;
    logic               r_hit;

    logic               r_rd_valid;
    t_shape             r_rd_shape;
    t_corner            r_rd_corner;

    logic               r_out_valid;
    logic               r_out_collides;
    logic               r_out_outside;

    t_pipe_status       pipe_status;

    logic               in_accept;
    logic               out_free;
    logic               is_load;
    logic               outside;
    logic               load_in_range;
    logic [SCAN_W-1:0]  scan_len;
    logic               last_idx;
    logic               rd_en;
    logic               drain_done;
    logic               start_scan;
    logic               quick_result;

    // world bounds: pos < r or pos + r > world_size on either axis
    assign outside =
        (i_pos_x < COORD_W'(i_circle_radius)) ||
        (i_pos_y < COORD_W'(i_circle_radius)) ||
        ((COORD_W+1)'(i_pos_x) + (COORD_W+1)'(i_circle_radius) >
         (COORD_W+1)'(r_world_size)) ||
        ((COORD_W+1)'(i_pos_y) + (COORD_W+1)'(i_circle_radius) >
         (COORD_W+1)'(r_world_size));

    assign scan_len = (32'(r_obstacle_count) > MAX_OBSTACLES) ?
                      SCAN_W'(MAX_OBSTACLES) : SCAN_W'(r_obstacle_count);

    assign load_in_range = 32'(i_entry_index) < MAX_OBSTACLES;
    assign is_load       = (i_req_type == REQ_LOAD);
    assign out_free      = !r_out_valid || !i_out_stall;
    assign in_accept     = i_in_valid && !o_in_stall;
    assign last_idx      = (32'(r_idx) == 32'(scan_len) - 1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept && !is_load && !outside && scan_len != '0) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (last_idx) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_valid && !pipe_status.busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall   = 1'b1;
        rd_en        = 1'b0;
        drain_done   = 1'b0;
        start_scan   = 1'b0;
        quick_result = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall   = !out_free;
                start_scan   = in_accept && !is_load && !outside && scan_len != '0;
                quick_result = in_accept && !start_scan;
            end
            S_SCAN: begin
                rd_en = 1'b1;
            end
            S_DRAIN: begin
                drain_done = !r_rd_valid && !pipe_status.busy;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_world_size     <= WORLD_SIZE_RST;
            r_obstacle_count <= '0;
            r_rd_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_idx            <= '0;
            r_hit            <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= rd_en;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WORLD_SIZE:     r_world_size     <= i_cfg_data[COORD_W-1:0];
                    CFG_OBSTACLE_COUNT: r_obstacle_count <= i_cfg_data[COUNT_W-1:0];
                    default:            ;
                endcase
            end

            if (start_scan) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else begin
                if (rd_en) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
                if (pipe_status.hit_valid && pipe_status.hit) begin
                    r_hit <= 1'b1;
                end
            end

            if (quick_result || drain_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        if (quick_result) begin
            r_out_collides <= !is_load && outside;
            r_out_outside  <= !is_load && outside;
        end else if (drain_done) begin
            r_out_collides <= r_hit;
            r_out_outside  <= 1'b0;
        end

        if (start_scan) begin
            r_query.x      <= i_pos_x;
            r_query.y      <= i_pos_y;
            r_query.radius <= i_circle_radius;
        end
    end

    // obstacle memory: one write port for loads, one registered read port for scans
    always_ff @(posedge i_clk) begin
        if (in_accept && is_load && load_in_range) begin
            shape_mem[IDX_W'(i_entry_index)]  <= '{kind: i_entry_kind, x: i_pos_x,
                                                   y: i_pos_y, radius: i_circle_radius};
            corner_mem[IDX_W'(i_entry_index)] <= '{x: i_corner_x, y: i_corner_y};
        end
        if (rd_en) begin
            r_rd_shape  <= shape_mem[r_idx];
            r_rd_corner <= corner_mem[r_idx];
        end
    end

    cocc_hit_pipe u_hit_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_rd_valid),
        .i_shape  (r_rd_shape),
        .i_corner (r_rd_corner),
        .i_query  (r_query),
        .o_status (pipe_status)
    );

    assign o_cfg_ready         = 1'b1;
    assign o_out_valid         = r_out_valid;
    assign o_out_collides      = r_out_collides;
    assign o_out_outside_world = r_out_outside;

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (32'(r_idx) < 32'(scan_len)))
        else $error("scan read beyond obstacle count");

    a_no_result_while_scanning: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_out_valid)
        else $error("result pending during scan");

    a_outside_implies_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_outside) |-> r_out_collides)
        else $error("outside_world without collides");

    a_hits_only_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pipe_status.hit_valid |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("pipeline result outside a query");

endmodule
